@@ design/spimrt_pkg.sv @@
// Package for the SPI mode 3 register transaction master.
// Holds the phase and command types and the fixed command bytes.
// No dependencies.
`default_nettype none

package spimrt_pkg;

    // Serial phase of the bit engine
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEAD = 3'd1,
        PH_LOW  = 3'd2,
        PH_HIGH = 3'd3
    } t_phase;

    // Command codes on the tick channel
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BURST = 2'd3
    } t_cmd;

    localparam logic [7:0] READ_FLAG   = 8'h80;
    localparam logic [7:0] BURST_FLAGS = 8'hC0;
    localparam logic [7:0] BURST_START = 8'h32;
    localparam logic [7:0] FILL_BYTE   = 8'h00;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd16;

    // Bytes per transaction, address byte included
    localparam logic [2:0] BURST_BYTES = 3'd7;
    localparam logic [2:0] SHORT_BYTES = 3'd2;
    localparam logic [2:0] LAST_BIT    = 3'd7;

endpackage

`default_nettype wire

@@ design/spimrt_if.sv @@
// Channel interfaces of the SPI mode 3 register transaction master:
// tick input, per-tick pin/status result, and configuration write.
// Depends on nothing.
`default_nettype none

// One tick: optional command plus the sampled MISO level
interface spimrt_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] register_address;
    logic [7:0] write_value;
    logic       miso;

    modport source (output valid, command, register_address, write_value, miso,
                    input ready);
    modport sink   (input valid, command, register_address, write_value, miso,
                    output ready);
endinterface

// Pin levels and status after one tick
interface spimrt_res_if;
    logic               valid;
    logic               ready;
    logic               sck;
    logic               mosi;
    logic               cs_n;
    logic               busy_res;
    logic               done_res;
    logic        [7:0]  read_value;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, sck, mosi, cs_n, busy_res, done_res, read_value,
                           accel_x, accel_y, accel_z,
                    input ready);
    modport sink   (input valid, sck, mosi, cs_n, busy_res, done_res, read_value,
                          accel_x, accel_y, accel_z,
                    output ready);
endinterface

// Write of the half period register
interface spimrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/spi_mode3_register_transaction_master.sv @@
// Top level of the SPI mode 3 register transaction master.
// Depends on spimrt_pkg and the interfaces in spimrt_if.sv.
//
// Usage:
//   i_tick_ch carries one timer tick per transfer: a command (taken only when
//   idle), the register address, the write byte and the MISO level seen that
//   tick. Every tick transfer yields exactly one transfer on o_res_ch with the
//   pin levels (sck, mosi, cs_n) and status after that tick, plus the last read
//   byte and the X/Y/Z burst values.
//   i_cfg_ch writes half_period (ticks per clock half phase and chip select
//   lead time); it is always ready and must be written only while idle.
//   A tick's result is presented in the cycle after its transfer. Throughput:
//   one tick per cycle while results are taken; the tick logic is a single
//   pass between the engine state registers and the result register.
//   A result register parts the two sides: a new tick is taken while the
//   previous result waits, as long as that result is taken in the same cycle.
//   If the receiver stalls, o_res_ch holds its result and i_tick_ch.ready
//   drops until the result is taken; no tick is lost.
//   Reset (i_rst_n low, synchronous) returns the engine to idle, clears all
//   data registers, empties the result register and sets half_period to 16.
`default_nettype none

module spi_mode3_register_transaction_master (
    input  wire          i_clk,
    input  wire          i_rst_n,
    spimrt_tick_if.sink  i_tick_ch,
    spimrt_res_if.source o_res_ch,
    spimrt_cfg_if.sink   i_cfg_ch
);

    // Engine state
    spimrt_pkg::t_phase r_phase, n_phase;
    spimrt_pkg::t_cmd   r_cmd, n_cmd;
    logic [7:0]  r_half;
    logic [7:0]  r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [2:0]  r_byte, n_byte;
    logic [7:0]  r_out_shift, n_out_shift;
    logic [7:0]  r_in_shift, n_in_shift;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_last_read, n_last_read;
    logic [15:0] r_x, n_x;
    logic [15:0] r_y, n_y;
    logic [15:0] r_z, n_z;
    logic        n_done;

    // Result register
    logic        r_res_valid;
    logic        r_res_sck, r_res_mosi, r_res_cs_n, r_res_busy, r_res_done;

    logic        tick_xfer;
    logic [7:0]  tick_inc;
    logic [2:0]  byte_inc;
    logic [2:0]  byte_total;
    logic [7:0]  in_next;

    assign i_cfg_ch.ready  = 1'b1;
    assign i_tick_ch.ready = !r_res_valid || o_res_ch.ready;
    assign tick_xfer       = i_tick_ch.valid && i_tick_ch.ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= spimrt_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_ch.valid) begin
            r_half <= i_cfg_ch.data;
        end
    end

    // Next state of the bit engine for one tick
    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_held      = r_held;
        n_last_read = r_last_read;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_done      = 1'b0;
        tick_inc    = r_tick + 8'd1;
        byte_inc    = r_byte + 3'd1;
        byte_total  = (r_cmd == spimrt_pkg::CMD_BURST) ? spimrt_pkg::BURST_BYTES
                                                       : spimrt_pkg::SHORT_BYTES;
        in_next     = r_in_shift;

        if (r_phase == spimrt_pkg::PH_IDLE) begin
            // Start a transaction
            if (spimrt_pkg::t_cmd'(i_tick_ch.command) != spimrt_pkg::CMD_NONE) begin
                n_cmd      = spimrt_pkg::t_cmd'(i_tick_ch.command);
                n_held     = i_tick_ch.write_value;
                n_tick     = 8'd0;
                n_bit      = 3'd0;
                n_byte     = 3'd0;
                n_in_shift = 8'd0;
                n_phase    = spimrt_pkg::PH_LEAD;
                unique case (spimrt_pkg::t_cmd'(i_tick_ch.command))
                    spimrt_pkg::CMD_WRITE: n_out_shift = {2'b00, i_tick_ch.register_address};
                    spimrt_pkg::CMD_READ:  n_out_shift = spimrt_pkg::READ_FLAG
                                                       | {2'b00, i_tick_ch.register_address};
                    default:               n_out_shift = spimrt_pkg::BURST_FLAGS
                                                       | spimrt_pkg::BURST_START;
                endcase
            end
        end else if (tick_inc >= r_half) begin
            n_tick = 8'd0;
            unique case (r_phase)
                spimrt_pkg::PH_LEAD: begin
                    n_phase = spimrt_pkg::PH_LOW;
                end
                spimrt_pkg::PH_LOW: begin
                    // Sample MISO at the end of the low phase
                    n_in_shift = {r_in_shift[6:0], i_tick_ch.miso};
                    n_phase    = spimrt_pkg::PH_HIGH;
                end
                spimrt_pkg::PH_HIGH: begin
                    if (r_bit != spimrt_pkg::LAST_BIT) begin
                        n_bit       = r_bit + 3'd1;
                        n_out_shift = {r_out_shift[6:0], 1'b0};
                        n_phase     = spimrt_pkg::PH_LOW;
                    end else begin
                        // Byte boundary: store the received byte
                        if (r_cmd == spimrt_pkg::CMD_READ) begin
                            if (r_byte == 3'd1) n_last_read = in_next;
                        end else if (r_cmd == spimrt_pkg::CMD_BURST) begin
                            unique case (r_byte)
                                3'd1:    n_x[7:0]  = in_next;
                                3'd2:    n_x[15:8] = in_next;
                                3'd3:    n_y[7:0]  = in_next;
                                3'd4:    n_y[15:8] = in_next;
                                3'd5:    n_z[7:0]  = in_next;
                                3'd6:    n_z[15:8] = in_next;
                                default: ;
                            endcase
                        end
                        n_in_shift = 8'd0;
                        n_bit      = 3'd0;
                        if (byte_inc < byte_total) begin
                            n_byte      = byte_inc;
                            n_out_shift = (r_cmd == spimrt_pkg::CMD_WRITE && byte_inc == 3'd1)
                                        ? r_held : spimrt_pkg::FILL_BYTE;
                            n_phase     = spimrt_pkg::PH_LOW;
                        end else begin
                            n_out_shift = 8'd0;
                            n_byte      = 3'd0;
                            n_phase     = spimrt_pkg::PH_IDLE;
                            n_done      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = spimrt_pkg::PH_IDLE;
                end
            endcase
        end else begin
            n_tick = tick_inc;
        end
    end

    // Engine state registers, advanced once per tick transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= spimrt_pkg::PH_IDLE;
            r_cmd       <= spimrt_pkg::CMD_NONE;
            r_tick      <= 8'd0;
            r_bit       <= 3'd0;
            r_byte      <= 3'd0;
            r_out_shift <= 8'd0;
            r_in_shift  <= 8'd0;
            r_held      <= 8'd0;
            r_last_read <= 8'd0;
            r_x         <= 16'd0;
            r_y         <= 16'd0;
            r_z         <= 16'd0;
        end else if (tick_xfer) begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_held      <= n_held;
            r_last_read <= n_last_read;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (tick_xfer) begin
            r_res_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result pin levels; data outputs come straight from the engine registers
    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_res_sck  <= (n_phase != spimrt_pkg::PH_LOW);
            r_res_mosi <= (n_phase != spimrt_pkg::PH_IDLE) && n_out_shift[7];
            r_res_cs_n <= (n_phase == spimrt_pkg::PH_IDLE);
            r_res_busy <= (n_phase != spimrt_pkg::PH_IDLE);
            r_res_done <= n_done;
        end
    end

    assign o_res_ch.valid      = r_res_valid;
    assign o_res_ch.sck        = r_res_sck;
    assign o_res_ch.mosi       = r_res_mosi;
    assign o_res_ch.cs_n       = r_res_cs_n;
    assign o_res_ch.busy_res   = r_res_busy;
    assign o_res_ch.done_res   = r_res_done;
    assign o_res_ch.read_value = r_last_read;
    assign o_res_ch.accel_x    = $signed(r_x);
    assign o_res_ch.accel_y    = $signed(r_y);
    assign o_res_ch.accel_z    = $signed(r_z);

    // Idle pins: chip select high means clock high and data low
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_cs_n |-> r_res_sck && !r_res_mosi && !r_res_busy)
        else $error("idle result with active pin levels");

    // Done pulse only when the transaction has ended
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_done |-> r_res_cs_n && r_phase == spimrt_pkg::PH_IDLE)
        else $error("done pulse while still busy");

    // Idle engine keeps its counters cleared
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == spimrt_pkg::PH_IDLE |-> r_bit == 3'd0 && r_byte == 3'd0
                                         && r_out_shift == 8'd0)
        else $error("idle engine with nonzero bit or byte count");

    // A stalled result stays until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !o_res_ch.ready |=> r_res_valid && !$past(tick_xfer))
        else $error("result dropped or tick taken during stall");

    // The tick engine only moves on a transfer
    a_engine_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_xfer |=> $stable(r_phase) && $stable(r_tick))
        else $error("engine advanced without a tick transfer");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Bench for spi_mode3_register_transaction_master: drives SPI commands and MISO levels
// tick by tick, predicts the pin and status levels of every tick and compares them.
// Depends on spimrt_pkg and the channel interfaces in spimrt_if.sv.

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 40;
    localparam int RAND_TICKS     = 200;

    typedef enum int {MISO_LOW, MISO_HIGH, MISO_RAND} t_miso_mode;

    typedef struct {
        spimrt_pkg::t_cmd cmd;
        logic [5:0]       addr;
        logic [7:0]       wval;
        logic             miso;
    } t_tick;

    typedef struct {
        logic        sck;
        logic        mosi;
        logic        cs_n;
        logic        busy;
        logic        done;
        logic [7:0]  rd;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
    } t_pins;

    typedef struct {
        spimrt_pkg::t_phase phase;
        spimrt_pkg::t_cmd   cmd;
        logic [7:0]         tick_cnt;
        logic [2:0]         bit_idx;
        logic [2:0]         byte_idx;
        logic [7:0]         out_sh;
        logic [7:0]         in_sh;
        logic [7:0]         held_wr;
        logic [7:0]         last_rd;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        z;
    } t_engine;

    // One directed transaction; hp < 0 keeps the current half period
    typedef struct {
        int               hp;
        spimrt_pkg::t_cmd cmd;
        logic [5:0]       addr;
        logic [7:0]       wval;
        t_miso_mode       miso;
        bit               busy_cmds;
        bit               typed;
        logic [7:0]       rd;
        logic [15:0]      ax;
        logic [15:0]      ay;
        logic [15:0]      az;
    } t_dir_row;

    logic clk;
    logic rst_n;

    spimrt_tick_if tick_ch ();
    spimrt_res_if  res_ch ();
    spimrt_cfg_if  cfg_ch ();

    spi_mode3_register_transaction_master u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_tick_ch (tick_ch),
        .o_res_ch  (res_ch),
        .i_cfg_ch  (cfg_ch)
    );

    // Predictor state and bookkeeping
    t_engine    eng;
    logic [7:0] hp_setting;
    t_pins      pins_due [$];
    t_pins      last_pins;
    bit         idle_on;
    int         stall_left;
    int         stall_draw;
    int         quiet_cycles;
    int         n_mismatch;
    int         n_ticks;
    int         n_writes;
    int         n_reads;
    int         n_bursts;
    int         n_cfg;
    t_dir_row   dir_rows [13];

    always #2 clk = ~clk;

    // Expected pin levels after one tick; advances the engine copy
    function automatic t_pins next_pins(input t_tick t);
        t_pins r;
        logic  done;
        done = 1'b0;
        if (eng.phase == spimrt_pkg::PH_IDLE) begin
            if (t.cmd != spimrt_pkg::CMD_NONE) begin
                eng.cmd      = t.cmd;
                eng.held_wr  = t.wval;
                eng.tick_cnt = '0;
                eng.bit_idx  = '0;
                eng.byte_idx = '0;
                eng.in_sh    = '0;
                case (t.cmd)
                    spimrt_pkg::CMD_WRITE: eng.out_sh = {2'b00, t.addr};
                    spimrt_pkg::CMD_READ:  eng.out_sh = spimrt_pkg::READ_FLAG | {2'b00, t.addr};
                    default: eng.out_sh = spimrt_pkg::BURST_FLAGS | spimrt_pkg::BURST_START;
                endcase
                eng.phase = spimrt_pkg::PH_LEAD;
            end
        end else begin
            eng.tick_cnt = eng.tick_cnt + 8'd1;
            if (eng.tick_cnt >= hp_setting) begin
                eng.tick_cnt = '0;
                case (eng.phase)
                    spimrt_pkg::PH_LEAD: eng.phase = spimrt_pkg::PH_LOW;
                    spimrt_pkg::PH_LOW: begin
                        eng.in_sh = {eng.in_sh[6:0], t.miso};
                        eng.phase = spimrt_pkg::PH_HIGH;
                    end
                    default: begin
                        if (eng.bit_idx != spimrt_pkg::LAST_BIT) begin
                            eng.bit_idx = eng.bit_idx + 3'd1;
                            eng.out_sh  = {eng.out_sh[6:0], 1'b0};
                            eng.phase   = spimrt_pkg::PH_LOW;
                        end else begin
                            // byte complete: keep it where the command wants it
                            if (eng.cmd == spimrt_pkg::CMD_READ && eng.byte_idx == 3'd1)
                                eng.last_rd = eng.in_sh;
                            else if (eng.cmd == spimrt_pkg::CMD_BURST) begin
                                case (eng.byte_idx)
                                    3'd1: eng.x[7:0]  = eng.in_sh;
                                    3'd2: eng.x[15:8] = eng.in_sh;
                                    3'd3: eng.y[7:0]  = eng.in_sh;
                                    3'd4: eng.y[15:8] = eng.in_sh;
                                    3'd5: eng.z[7:0]  = eng.in_sh;
                                    3'd6: eng.z[15:8] = eng.in_sh;
                                    default: ;
                                endcase
                            end
                            eng.in_sh    = '0;
                            eng.bit_idx  = '0;
                            eng.byte_idx = eng.byte_idx + 3'd1;
                            if (eng.byte_idx < ((eng.cmd == spimrt_pkg::CMD_BURST)
                                    ? spimrt_pkg::BURST_BYTES : spimrt_pkg::SHORT_BYTES)) begin
                                eng.out_sh = (eng.cmd == spimrt_pkg::CMD_WRITE
                                              && eng.byte_idx == 3'd1)
                                             ? eng.held_wr : spimrt_pkg::FILL_BYTE;
                                eng.phase  = spimrt_pkg::PH_LOW;
                            end else begin
                                eng.out_sh   = '0;
                                eng.byte_idx = '0;
                                eng.phase    = spimrt_pkg::PH_IDLE;
                                done         = 1'b1;
                                case (eng.cmd)
                                    spimrt_pkg::CMD_WRITE: n_writes++;
                                    spimrt_pkg::CMD_READ:  n_reads++;
                                    default:               n_bursts++;
                                endcase
                            end
                        end
                    end
                endcase
            end
        end
        r.sck  = (eng.phase != spimrt_pkg::PH_LOW);
        r.mosi = (eng.phase == spimrt_pkg::PH_IDLE) ? 1'b0 : eng.out_sh[7];
        r.cs_n = (eng.phase == spimrt_pkg::PH_IDLE);
        r.busy = (eng.phase != spimrt_pkg::PH_IDLE);
        r.done = done;
        r.rd   = eng.last_rd;
        r.ax   = eng.x;
        r.ay   = eng.y;
        r.az   = eng.z;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("tb: mismatch at %0t on %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic compare_pins(input t_pins got, input t_pins want);
        if (got.sck  !== want.sck)  flag_mismatch("sck", got.sck, want.sck);
        if (got.mosi !== want.mosi) flag_mismatch("mosi", got.mosi, want.mosi);
        if (got.cs_n !== want.cs_n) flag_mismatch("cs_n", got.cs_n, want.cs_n);
        if (got.busy !== want.busy) flag_mismatch("busy_res", got.busy, want.busy);
        if (got.done !== want.done) flag_mismatch("done_res", got.done, want.done);
        if (got.rd   !== want.rd)   flag_mismatch("read_value", got.rd, want.rd);
        if (got.ax   !== want.ax)   flag_mismatch("accel_x", got.ax, want.ax);
        if (got.ay   !== want.ay)   flag_mismatch("accel_y", got.ay, want.ay);
        if (got.az   !== want.az)   flag_mismatch("accel_z", got.az, want.az);
    endtask

    function automatic logic pick_miso(input t_miso_mode mode);
        case (mode)
            MISO_LOW:  return 1'b0;
            MISO_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // One tick transfer, after a random gap while idle_on is set; valid stays high on return
    task automatic send_tick(input t_tick t);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid            <= 1'b1;
        tick_ch.command          <= t.cmd;
        tick_ch.register_address <= t.addr;
        tick_ch.write_value      <= t.wval;
        tick_ch.miso             <= t.miso;
        do @(posedge clk); while (!tick_ch.ready);
        pins_due.push_back(next_pins(t));
        n_ticks++;
    endtask

    // Sender holds off until every predicted tick result has come back
    task automatic wait_for_results();
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (pins_due.size() != 0);
    endtask

    task automatic set_half_period(input logic [7:0] v);
        wait_for_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        hp_setting = v;
        n_cfg++;
    endtask

    // Command tick, then ticks until the engine is idle again
    task automatic run_transaction(input spimrt_pkg::t_cmd cmd, input logic [5:0] addr,
                                   input logic [7:0] wval, input t_miso_mode mode,
                                   input bit busy_cmds, input int pause_permille);
        t_tick t;
        t = '{cmd: cmd, addr: addr, wval: wval, miso: pick_miso(mode)};
        send_tick(t);
        while (eng.phase != spimrt_pkg::PH_IDLE) begin
            // commands while busy must be ignored
            t.cmd  = (busy_cmds && $urandom_range(0, 3) == 0)
                     ? spimrt_pkg::t_cmd'($urandom_range(1, 3)) : spimrt_pkg::CMD_NONE;
            t.addr = 6'($urandom_range(0, 63));
            t.wval = 8'($urandom_range(0, 255));
            t.miso = pick_miso(mode);
            if ($urandom_range(0, 999) < pause_permille)
                wait_for_results();
            send_tick(t);
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            last_pins = '{res_ch.sck, res_ch.mosi, res_ch.cs_n, res_ch.busy_res,
                          res_ch.done_res, res_ch.read_value, res_ch.accel_x,
                          res_ch.accel_y, res_ch.accel_z};
            if (pins_due.size() == 0)
                flag_mismatch("result with none pending", 16'd1, 16'd0);
            else
                compare_pins(last_pins, pins_due.pop_front());
            stall_draw = idle_on ? $urandom_range(0, 5) : 0;
            if (stall_draw != 0) begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall_draw;
            end
        end else if (!res_ch.ready) begin
            if (stall_left <= 1)
                res_ch.ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int               rand_start;
        spimrt_pkg::t_cmd cmd;
        int               pick;

        clk                       = 1'b0;
        rst_n                    <= 1'b0;
        tick_ch.valid            <= 1'b0;
        tick_ch.command          <= spimrt_pkg::CMD_NONE;
        tick_ch.register_address <= '0;
        tick_ch.write_value      <= '0;
        tick_ch.miso             <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.data              <= '0;
        eng        = '{phase: spimrt_pkg::PH_IDLE, cmd: spimrt_pkg::CMD_NONE, default: '0};
        hp_setting = spimrt_pkg::HALF_PERIOD_RESET;
        idle_on    = 1'b1;
        n_mismatch = 0;
        n_ticks    = 0;
        n_writes   = 0;
        n_reads    = 0;
        n_bursts   = 0;
        n_cfg      = 0;

        // hp, cmd, addr, wval, miso, busy cmds, typed, read, x, y, z
        dir_rows = '{
            // idle levels right after reset
            '{-1, spimrt_pkg::CMD_NONE,  6'h00, 8'h00, MISO_LOW,  1'b0, 1'b1, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            // write leaves read and axes alone; top address bits sent as zero
            '{1, spimrt_pkg::CMD_WRITE,  6'h3F, 8'hFF, MISO_LOW,  1'b0, 1'b1, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            '{-1, spimrt_pkg::CMD_READ,  6'h00, 8'hFF, MISO_HIGH, 1'b0, 1'b1, 8'hFF,
              16'h0000, 16'h0000, 16'h0000},
            '{-1, spimrt_pkg::CMD_READ,  6'h3F, 8'h00, MISO_LOW,  1'b0, 1'b1, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            // burst ignores the address; all ones gives -1 on every axis
            '{-1, spimrt_pkg::CMD_BURST, 6'h00, 8'h00, MISO_HIGH, 1'b0, 1'b1, 8'h00,
              16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{-1, spimrt_pkg::CMD_BURST, 6'h3F, 8'hFF, MISO_LOW,  1'b0, 1'b1, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            '{2, spimrt_pkg::CMD_READ,   6'h2A, 8'h00, MISO_HIGH, 1'b0, 1'b1, 8'hFF,
              16'h0000, 16'h0000, 16'h0000},
            '{-1, spimrt_pkg::CMD_WRITE, 6'h15, 8'hA5, MISO_RAND, 1'b1, 1'b1, 8'hFF,
              16'h0000, 16'h0000, 16'h0000},
            '{1, spimrt_pkg::CMD_WRITE,  6'h00, 8'h00, MISO_RAND, 1'b1, 1'b0, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            // zero half period runs like one
            '{0, spimrt_pkg::CMD_READ,   6'h15, 8'h3C, MISO_RAND, 1'b1, 1'b0, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            '{0, spimrt_pkg::CMD_WRITE,  6'h2A, 8'hC3, MISO_RAND, 1'b1, 1'b0, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            // no command while idle
            '{1, spimrt_pkg::CMD_NONE,   6'h3F, 8'hFF, MISO_HIGH, 1'b0, 1'b0, 8'h00,
              16'h0000, 16'h0000, 16'h0000},
            '{3, spimrt_pkg::CMD_READ,   6'h32, 8'h00, MISO_RAND, 1'b1, 1'b0, 8'h00,
              16'h0000, 16'h0000, 16'h0000}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions
        foreach (dir_rows[i]) begin
            idle_on = (i % 3 != 2);
            if (dir_rows[i].hp >= 0)
                set_half_period(dir_rows[i].hp[7:0]);
            run_transaction(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].wval,
                            dir_rows[i].miso, dir_rows[i].busy_cmds, 0);
            wait_for_results();
            if (dir_rows[i].typed) begin
                if (last_pins.cs_n !== 1'b1)
                    flag_mismatch("idle cs_n", last_pins.cs_n, 16'd1);
                if (last_pins.sck  !== 1'b1)
                    flag_mismatch("idle sck", last_pins.sck, 16'd1);
                if (last_pins.mosi !== 1'b0)
                    flag_mismatch("idle mosi", last_pins.mosi, 16'd0);
                if (last_pins.busy !== 1'b0)
                    flag_mismatch("idle busy", last_pins.busy, 16'd0);
                if (last_pins.rd !== dir_rows[i].rd)
                    flag_mismatch("row read_value", last_pins.rd, dir_rows[i].rd);
                if (last_pins.ax !== dir_rows[i].ax)
                    flag_mismatch("row accel_x", last_pins.ax, dir_rows[i].ax);
                if (last_pins.ay !== dir_rows[i].ay)
                    flag_mismatch("row accel_y", last_pins.ay, dir_rows[i].ay);
                if (last_pins.az !== dir_rows[i].az)
                    flag_mismatch("row accel_z", last_pins.az, dir_rows[i].az);
            end
        end

        // Random phases: short half periods, a new setting per phase
        rand_start = n_ticks;
        while (n_ticks - rand_start < RAND_TICKS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                set_half_period(8'd0);
            else if (pick <= 8)
                set_half_period(8'($urandom_range(1, 2)));
            else
                set_half_period(8'd3);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    // idle noise: ticks without a command
                    repeat ($urandom_range(1, 4))
                        send_tick('{cmd: spimrt_pkg::CMD_NONE,
                                    addr: 6'($urandom_range(0, 63)),
                                    wval: 8'($urandom_range(0, 255)),
                                    miso: 1'($urandom_range(0, 1))});
                end else begin
                    cmd = spimrt_pkg::t_cmd'($urandom_range(1, 3));
                    run_transaction(cmd, 6'($urandom_range(0, 63)),
                                    8'($urandom_range(0, 255)), MISO_RAND, 1'b1, 2);
                end
            end
        end

        wait_for_results();
        repeat (4) @(posedge clk);

        $display("summary: %0d ticks; %0d writes, %0d reads, %0d bursts completed",
                 n_ticks, n_writes, n_reads, n_bursts);
        $display("summary: %0d half period writes (0 through 3), %0d mismatches",
                 n_cfg, n_mismatch);
        if (n_mismatch == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/spimrt_pkg.sv
design/spimrt_if.sv
design/spi_mode3_register_transaction_master.sv
bench/tb.sv
